@@ rtl/kspe_pkg.sv @@
// Package with the shared constants, types and the key map of the keypad scanner.
`timescale 1ns / 1ps
package kspe_pkg;

   localparam int DIGITS_DEFAULT = 4;

   localparam int TICK_W   = 8;
   localparam int PIN_W    = 16;
   localparam int COUNT_W  = 3;

   // Configuration register indexes
   localparam logic CSR_SETTLE = 1'b0;
   localparam logic CSR_POLL   = 1'b1;

   localparam logic [TICK_W-1:0] SETTLE_RESET = 8'd2;
   localparam logic [TICK_W-1:0] POLL_RESET   = 8'd10;

   localparam logic [3:0] KEY_STAR = 4'd14;
   localparam logic [3:0] KEY_HASH = 4'd15;
   localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;

   typedef struct packed {
      logic       valid;
      logic [3:0] code;
   } key_event_type;

   typedef struct packed {
      logic [3:0]         row_drive;
      logic               key_valid;
      logic [3:0]         key_code;
      logic               pin_saved;
      logic [PIN_W-1:0]   pin_digits;
      logic [COUNT_W-1:0] digit_count;
   } result_type;

   // Key at a given row and column of the 4x4 matrix.
   function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
      logic [3:0] k;
      case ({row, col})
         4'h0:    k = 4'd1;
         4'h1:    k = 4'd2;
         4'h2:    k = 4'd3;
         4'h3:    k = 4'd10;
         4'h4:    k = 4'd4;
         4'h5:    k = 4'd5;
         4'h6:    k = 4'd6;
         4'h7:    k = 4'd11;
         4'h8:    k = 4'd7;
         4'h9:    k = 4'd8;
         4'hA:    k = 4'd9;
         4'hB:    k = 4'd12;
         4'hC:    k = KEY_STAR;
         4'hD:    k = 4'd0;
         4'hE:    k = KEY_HASH;
         default: k = 4'd13;
      endcase
      return k;
   endfunction

endpackage

@@ rtl/keypad_scan_pin_entry_unit.sv @@
// Top level of the 4x4 keypad scanner with PIN entry.
//
//  channel  ports               direction  content
//  req      req_valid/ready     in         column levels of one tick
//  rsp      rsp_valid/ready     out        row drive, key, saved PIN, digit count
//  csr      csr_wr_en           in         settle and release poll tick counts
//
// One tick is taken per clock cycle while req_ready is high; its result is
// registered in the output buffer. The scan state and entry buffer update in the
// cycle of the transfer. A two-entry output buffer takes one more input transfer
// while the result side stalls; req_ready drops only when both entries are full.
// Reset is synchronous and restores the register defaults (settle 2, poll 10).
`timescale 1ns / 1ps
module keypad_scan_pin_entry_unit #(
   parameter int DIGITS = kspe_pkg::DIGITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_col_levels,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [3:0]                   rsp_row_drive,
   output logic                         rsp_key_valid,
   output logic [3:0]                   rsp_key_code,
   output logic                         rsp_pin_saved,
   output logic [kspe_pkg::PIN_W-1:0]   rsp_pin_digits,
   output logic [kspe_pkg::COUNT_W-1:0] rsp_digit_count,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [kspe_pkg::TICK_W-1:0]  csr_wdata
);

   logic                         tick;
   logic [3:0]                   row_drive;
   kspe_pkg::key_event_type      key_event;
   logic                         pin_saved;
   logic [kspe_pkg::PIN_W-1:0]   pin_digits;
   logic [kspe_pkg::COUNT_W-1:0] digit_count;
   kspe_pkg::result_type         result;
   kspe_pkg::result_type         rsp_data;

   assign tick = req_valid && req_ready;

   kspe_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .tick       (tick),
      .col_levels (req_col_levels),
      .row_drive  (row_drive),
      .key_event  (key_event)
   );

   kspe_entry #(
      .DIGITS (DIGITS)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .key_event   (key_event),
      .pin_saved   (pin_saved),
      .pin_digits  (pin_digits),
      .digit_count (digit_count)
   );

   assign result = {row_drive, key_event.valid, key_event.code, pin_saved, pin_digits,
                    digit_count};

   kspe_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_row_drive   = rsp_data.row_drive;
   assign rsp_key_valid   = rsp_data.key_valid;
   assign rsp_key_code    = rsp_data.key_code;
   assign rsp_pin_saved   = rsp_data.pin_saved;
   assign rsp_pin_digits  = rsp_data.pin_digits;
   assign rsp_digit_count = rsp_data.digit_count;

endmodule

@@ rtl/kspe_scan.sv @@
// Row scan state machine with the settle and release poll timers.
`timescale 1ns / 1ps
module kspe_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [kspe_pkg::TICK_W-1:0] csr_wdata,
   input  logic                        tick,
   input  logic [3:0]                  col_levels,
   output logic [3:0]                  row_drive,
   output kspe_pkg::key_event_type     key_event
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_SCAN    = 2'd1;
   localparam logic [1:0] PH_RELEASE = 2'd2;

   logic [kspe_pkg::TICK_W-1:0] settle_ff;
   logic [kspe_pkg::TICK_W-1:0] poll_ff;
   logic [1:0]                  phase_ff, phase_in;
   logic [1:0]                  col_ff, col_in;
   logic [1:0]                  row_ff, row_in;
   logic [kspe_pkg::TICK_W-1:0] wait_ff, wait_in;
   logic                        found_ff, found_in;
   logic [3:0]                  key_ff, key_in;
   logic                        col_high;
   logic                        timer_done;

   assign col_high   = col_levels[col_ff];
   assign timer_done = (wait_ff <= 8'd1);

   always_comb begin
      phase_in  = phase_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      wait_in   = wait_ff;
      found_in  = found_ff;
      key_in    = key_ff;
      row_drive = 4'b0000;
      key_event = '0;
      case (phase_ff)
         PH_SCAN: begin
            if (timer_done) begin
               if (col_high) begin
                  found_in = 1'b1;
                  key_in   = kspe_pkg::key_lookup(row_ff, col_ff);
                  phase_in = PH_RELEASE;
                  wait_in  = '0;
               end else if (row_ff == 2'd3) begin
                  phase_in = PH_RELEASE;
                  wait_in  = '0;
               end else begin
                  row_in    = row_ff + 2'd1;
                  wait_in   = settle_ff;
                  row_drive = 4'b0001 << row_in;
               end
            end else begin
               wait_in   = wait_ff - 8'd1;
               row_drive = 4'b0001 << row_ff;
            end
         end
         PH_RELEASE: begin
            if (timer_done) begin
               if (col_high) begin
                  phase_in        = PH_IDLE;
                  found_in        = 1'b0;
                  key_event.valid = found_ff;
                  key_event.code  = found_ff ? key_ff : 4'd0;
               end else begin
                  wait_in = poll_ff;
               end
            end else begin
               wait_in = wait_ff - 8'd1;
            end
         end
         default: begin
            // A press starts the scan at once: the lowest low column is taken.
            if (col_levels != 4'hF) begin
               if (!col_levels[0]) begin
                  col_in = 2'd0;
               end else if (!col_levels[1]) begin
                  col_in = 2'd1;
               end else if (!col_levels[2]) begin
                  col_in = 2'd2;
               end else begin
                  col_in = 2'd3;
               end
               row_in    = 2'd0;
               wait_in   = settle_ff;
               found_in  = 1'b0;
               phase_in  = PH_SCAN;
               row_drive = 4'b0001;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= kspe_pkg::SETTLE_RESET;
         poll_ff   <= kspe_pkg::POLL_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == kspe_pkg::CSR_SETTLE) begin
            settle_ff <= csr_wdata;
         end else begin
            poll_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         wait_ff  <= '0;
         found_ff <= 1'b0;
         key_ff   <= '0;
      end else if (tick) begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         wait_ff  <= wait_in;
         found_ff <= found_in;
         key_ff   <= key_in;
      end
   end

   a_idle_no_found: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !found_ff)
      else $error("key held while idle");
   a_release_rows_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RELEASE) |-> (row_drive == 4'b0000))
      else $error("rows driven while waiting for release");
   a_event_from_release: assert property (@(posedge clock) disable iff (reset)
      key_event.valid |-> (phase_ff == PH_RELEASE && found_ff))
      else $error("key reported outside release");
   a_scan_onehot: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SCAN && !timer_done) |-> $onehot(row_drive))
      else $error("scan drives other than one row");

endmodule

@@ rtl/kspe_entry.sv @@
// PIN entry buffer: appends digits, clears on star, saves the PIN on hash when full.
`timescale 1ns / 1ps
module kspe_entry #(
   parameter int DIGITS = kspe_pkg::DIGITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   input  kspe_pkg::key_event_type      key_event,
   output logic                         pin_saved,
   output logic [kspe_pkg::PIN_W-1:0]   pin_digits,
   output logic [kspe_pkg::COUNT_W-1:0] digit_count
);

   localparam int CNT_W = $clog2(DIGITS + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DIGITS);

   logic [3:0]             digit_ff [DIGITS];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [DIGITS*4-1:0]    flat;
   logic [DIGITS*4+kspe_pkg::PIN_W-1:0] flat_ext;
   logic [CNT_W+kspe_pkg::COUNT_W-1:0]  count_ext;
   logic                   do_append;
   logic                   do_save;
   logic                   do_clear;

   // Oldest digit lands in the highest nibble.
   for (genvar i = 0; i < DIGITS; i++) begin : g_flat
      assign flat[(DIGITS-1-i)*4 +: 4] = digit_ff[i];
   end

   assign do_append = key_event.valid && (key_event.code <= kspe_pkg::KEY_MAX_DIGIT)
                      && (count_ff < FULL);
   assign do_save   = key_event.valid && (key_event.code == kspe_pkg::KEY_HASH)
                      && (count_ff == FULL);
   assign do_clear  = key_event.valid && (key_event.code == kspe_pkg::KEY_STAR);

   always_comb begin
      count_in = count_ff;
      if (do_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_save || do_clear) begin
         count_in = '0;
      end
   end

   assign flat_ext    = {{kspe_pkg::PIN_W{1'b0}}, flat};
   assign pin_saved   = do_save;
   assign pin_digits  = do_save ? flat_ext[kspe_pkg::PIN_W-1:0] : '0;
   assign count_ext   = {{kspe_pkg::COUNT_W{1'b0}}, count_in};
   assign digit_count = count_ext[kspe_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (tick) begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < DIGITS; i++) begin : g_digit
      always_ff @(posedge clock) begin
         if (tick && do_append && count_ff == CNT_W'(i)) begin
            digit_ff[i] <= key_event.code;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("digit count beyond buffer size");
   a_save_clears: assert property (@(posedge clock) disable iff (reset)
      (tick && do_save) |=> (count_ff == '0))
      else $error("buffer not cleared after saving the PIN");
   a_save_needs_full: assert property (@(posedge clock) disable iff (reset)
      pin_saved |-> (count_ff == FULL && !do_append))
      else $error("PIN saved from a partial buffer");

endmodule

@@ rtl/kspe_out_buf.sv @@
// Two-entry result buffer that decouples the tick input from the result consumer.
`timescale 1ns / 1ps
module kspe_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  kspe_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output kspe_pkg::result_type out_data
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   kspe_pkg::result_type main_ff;
   kspe_pkg::result_type skid_ff;
   logic                 push;
   logic                 pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign pop       = main_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !main_valid_ff) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (push) begin
         skid_ff <= in_data;
      end
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to the output register");
   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("transfer lost while the output stalled");

endmodule

@@ tb/tb_keypad_scan_pin_entry_unit.sv @@
// Self-checking testbench for the keypad scanner with PIN entry.
`timescale 1ns / 1ps
module tb_keypad_scan_pin_entry_unit;

   localparam int PIN_LEN     = kspe_pkg::DIGITS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;

   // Key at matrix position 4*row+col, one nibble each, position 0 in the low nibble.
   localparam logic [63:0] KEY_GRID = 64'hDF0E_C987_B654_A321;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_ROWS, SCAN_RELEASE} scan_phase_type;

   typedef struct packed {
      logic [3:0] cols;
      bit         typed;
      logic [3:0] rows;
      logic       kvalid;
      logic [3:0] code;
      logic [2:0] count;
   } dir_row_type;

   // Reset settings: settle 2, poll 10.
   localparam dir_row_type DIRECTED_TICKS [25] = '{
      '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 3'd0},      // idle after reset
      '{4'hE, 1'b1, 4'h1, 1'b0, 4'h0, 3'd0},      // press starts a scan on row 0
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hF, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hF, 1'b1, 4'h0, 1'b1, 4'h1, 3'd1},      // key 1 released and stored
      '{4'h0, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},      // all columns low, column 0 wins
      '{4'h2, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'h4, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'h6, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'h8, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hA, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hC, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},      // no row found on row 3
      '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 3'd1},      // release without a key
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hE, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},
      '{4'hF, 1'b0, 4'h0, 1'b0, 4'h0, 3'd0},      // row 3 pulls column 0 high
      '{4'hF, 1'b1, 4'h0, 1'b1, kspe_pkg::KEY_STAR, 3'd0} // star clears the entry
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [3:0]                    req_col_levels = 4'hF;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [3:0]                    rsp_row_drive;
   logic                          rsp_key_valid;
   logic [3:0]                    rsp_key_code;
   logic                          rsp_pin_saved;
   logic [kspe_pkg::PIN_W-1:0]    rsp_pin_digits;
   logic [kspe_pkg::COUNT_W-1:0]  rsp_digit_count;
   logic                          csr_wr_en = 1'b0;
   logic                          csr_index = kspe_pkg::CSR_SETTLE;
   logic [kspe_pkg::TICK_W-1:0]   csr_wdata = '0;

   keypad_scan_pin_entry_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_col_levels  (req_col_levels),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_drive   (rsp_row_drive),
      .rsp_key_valid   (rsp_key_valid),
      .rsp_key_code    (rsp_key_code),
      .rsp_pin_saved   (rsp_pin_saved),
      .rsp_pin_digits  (rsp_pin_digits),
      .rsp_digit_count (rsp_digit_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // Scanner state as the checker sees it.
   logic [7:0]      settle_cfg, poll_cfg;
   scan_phase_type  scan_ph;
   logic [1:0]      col_sel, row_sel;
   logic [7:0]      tick_cnt;
   logic            held_valid;
   logic [3:0]      held_code;
   logic [3:0]      pin_buf [PIN_LEN];
   int              pin_cnt;
   logic [3:0]      last_rows;

   kspe_pkg::result_type pending_scan_out [$];
   bit                   use_typed = 1'b0;
   kspe_pkg::result_type typed_out = '0;
   int                   mismatches = 0;
   int                   rsp_seen = 0;
   int                   cycle_count = 0;

   int           snd_idle_pct = 0;
   int           rcv_idle_pct = 0;
   bit           hold_req = 1'b0;
   int           hold_left = 0;

   // Virtual keypad that answers the row drive like real switches.
   bit           pad_down = 1'b0;
   bit           pad_stuck = 1'b0;
   logic [1:0]   pad_row = '0, pad_col = '0;
   int           pad_hold = 0;
   int           pad_gap = 0;

   function automatic void clear_pin_entry();
      for (int i = 0; i < PIN_LEN; i++) pin_buf[i] = '0;
      pin_cnt = 0;
   endfunction

   function automatic kspe_pkg::result_type scan_tick_predict(input logic [3:0] cols);
      kspe_pkg::result_type r;
      int                   c;
      logic [15:0]          acc;
      r = '0;
      case (scan_ph)
         SCAN_IDLE: begin
            if (cols != 4'hF) begin
               c = 0;
               while (c < 3 && cols[c]) c++;
               col_sel = 2'(c);
               row_sel = 2'd0;
               tick_cnt = settle_cfg;
               held_valid = 1'b0;
               scan_ph = SCAN_ROWS;
               r.row_drive = 4'b0001;
            end
         end
         SCAN_ROWS: begin
            if (tick_cnt <= 8'd1) begin
               if (cols[col_sel]) begin
                  held_valid = 1'b1;
                  held_code = KEY_GRID[4 * {row_sel, col_sel} +: 4];
                  scan_ph = SCAN_RELEASE;
                  tick_cnt = '0;
               end else if (row_sel == 2'd3) begin
                  scan_ph = SCAN_RELEASE;
                  tick_cnt = '0;
               end else begin
                  row_sel = row_sel + 2'd1;
                  tick_cnt = settle_cfg;
                  r.row_drive = 4'b0001 << row_sel;
               end
            end else begin
               tick_cnt = tick_cnt - 8'd1;
               r.row_drive = 4'b0001 << row_sel;
            end
         end
         default: begin
            if (tick_cnt <= 8'd1) begin
               if (cols[col_sel]) begin
                  scan_ph = SCAN_IDLE;
                  if (held_valid) begin
                     r.key_valid = 1'b1;
                     r.key_code = held_code;
                     if (held_code <= kspe_pkg::KEY_MAX_DIGIT && pin_cnt < PIN_LEN) begin
                        pin_buf[pin_cnt] = held_code;
                        pin_cnt++;
                     end else if (held_code == kspe_pkg::KEY_HASH
                                  && pin_cnt == PIN_LEN) begin
                        acc = '0;
                        for (int i = 0; i < PIN_LEN; i++) acc = {acc[11:0], pin_buf[i]};
                        r.pin_saved = 1'b1;
                        r.pin_digits = acc;
                        clear_pin_entry();
                     end else if (held_code == kspe_pkg::KEY_STAR) begin
                        clear_pin_entry();
                     end
                  end
                  held_valid = 1'b0;
               end else begin
                  tick_cnt = poll_cfg;
               end
            end else begin
               tick_cnt = tick_cnt - 8'd1;
            end
         end
      endcase
      r.digit_count = 3'(pin_cnt);
      last_rows = r.row_drive;
      return r;
   endfunction

   always @(posedge clock) begin : check_outputs
      kspe_pkg::result_type got, want;
      if (reset) begin
         settle_cfg = kspe_pkg::SETTLE_RESET;
         poll_cfg = kspe_pkg::POLL_RESET;
         scan_ph = SCAN_IDLE;
         col_sel = '0;
         row_sel = '0;
         tick_cnt = '0;
         held_valid = 1'b0;
         held_code = '0;
         last_rows = '0;
         clear_pin_entry();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == kspe_pkg::CSR_SETTLE) settle_cfg = csr_wdata;
            else poll_cfg = csr_wdata;
         end
         if (req_valid && req_ready) begin
            want = scan_tick_predict(req_col_levels);
            pending_scan_out.push_back(use_typed ? typed_out : want);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_row_drive, rsp_key_valid, rsp_key_code, rsp_pin_saved,
                   rsp_pin_digits, rsp_digit_count};
            if (pending_scan_out.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing expected", rsp_seen);
            end else begin
               want = pending_scan_out.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d: expected rows %h key %b/%h pin %b/%h count %0d",
                              rsp_seen, want.row_drive, want.key_valid, want.key_code,
                              want.pin_saved, want.pin_digits, want.digit_count);
                     $display("result %0d: got rows %h key %b/%h pin %b/%h count %0d",
                              rsp_seen, got.row_drive, got.key_valid, got.key_code,
                              got.pin_saved, got.pin_digits, got.digit_count);
                  end
               end
            end
            rsp_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** keypad_scan_pin_entry_unit: FAILED **");
         $finish;
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req) begin
         hold_req = 1'b0;
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
      end
   end

   task automatic offer_tick(input logic [3:0] cols, input bit typed,
                             input kspe_pkg::result_type fixed);
      while ($urandom_range(99, 0) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      use_typed = typed;
      typed_out = fixed;
      req_valid <= 1'b1;
      req_col_levels <= cols;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_scan_out.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_timing(input logic [7:0] settle, input logic [7:0] poll);
      csr_wr_en <= 1'b1;
      csr_index <= kspe_pkg::CSR_SETTLE;
      csr_wdata <= settle;
      @(negedge clock);
      csr_index <= kspe_pkg::CSR_POLL;
      csr_wdata <= poll;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Picks the next key, mostly digits and a hash once the entry is full.
   task automatic pad_press();
      int         roll;
      int         pos;
      logic [3:0] code;
      roll = $urandom_range(99, 0);
      pos = $urandom_range(15, 0);
      code = '0;
      if (pin_cnt < PIN_LEN) begin
         if (roll < 78) code = 4'($urandom_range(9, 0));
         else if (roll < 85) code = kspe_pkg::KEY_STAR;
         else if (roll < 88) code = kspe_pkg::KEY_HASH;
      end else begin
         if (roll < 60) code = kspe_pkg::KEY_HASH;
         else if (roll < 75) code = 4'($urandom_range(9, 0));
         else if (roll < 85) code = kspe_pkg::KEY_STAR;
      end
      if (roll < 88)
         for (int i = 0; i < 16; i++)
            if (KEY_GRID[4 * i +: 4] == code) pos = i;
      pad_row = 2'(pos >> 2);
      pad_col = 2'(pos);
   endtask

   task automatic pad_advance();
      if (!pad_down) begin
         if (pad_gap > 0) begin
            pad_gap--;
         end else begin
            pad_press();
            pad_down = 1'b1;
            pad_stuck = ($urandom_range(99, 0) < 4);
            pad_hold = ($urandom_range(99, 0) < 80) ? $urandom_range(2, 0)
                                                    : $urandom_range(30, 3);
         end
      end else if (scan_ph == SCAN_RELEASE) begin
         if (pad_hold == 0) begin
            pad_down = 1'b0;
            pad_gap = $urandom_range(4, 0);
         end else begin
            pad_hold--;
         end
      end else if ($urandom_range(199, 0) == 0) begin
         // Let go in the middle of a scan.
         pad_down = 1'b0;
         pad_gap = $urandom_range(4, 0);
      end
   endtask

   // A raised row pulls the pressed key's column high; otherwise the key holds it low.
   function automatic logic [3:0] pad_levels();
      logic [3:0] lv;
      lv = 4'hF;
      if ($urandom_range(99, 0) < 5) lv = 4'($urandom_range(15, 0));
      else if (pad_down) lv[pad_col] = !pad_stuck && last_rows[pad_row];
      return lv;
   endfunction

   initial begin
      kspe_pkg::result_type fixed;
      logic [7:0]           settle_val, poll_val;
      int                   count;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_TICKS[i]) begin
         fixed = '0;
         fixed.row_drive = DIRECTED_TICKS[i].rows;
         fixed.key_valid = DIRECTED_TICKS[i].kvalid;
         fixed.key_code = DIRECTED_TICKS[i].code;
         fixed.digit_count = DIRECTED_TICKS[i].count;
         offer_tick(DIRECTED_TICKS[i].cols, DIRECTED_TICKS[i].typed, fixed);
      end

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin settle_val = 8'd0;   poll_val = 8'd0;   count = 350; end
            1: begin settle_val = 8'd255; poll_val = 8'd1;   count = 300; end
            2: begin settle_val = 8'd1;   poll_val = 8'd255; count = 300; end
            3: begin
               settle_val = 8'($urandom_range(4, 1));
               poll_val = 8'($urandom_range(4, 1));
               count = 450;
            end
            default: begin
               settle_val = 8'($urandom_range(6, 1));
               poll_val = 8'($urandom_range(6, 1));
               count = 400;
            end
         endcase
         drain_results();
         program_timing(settle_val, poll_val);
         snd_idle_pct = (phase < 2) ? 13 : (phase < 4) ? 63 : 0;
         rcv_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 13 : 0;
         if (phase == 4) hold_req = 1'b1;
         repeat (count) begin
            pad_advance();
            offer_tick(pad_levels(), 1'b0, '0);
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("** keypad_scan_pin_entry_unit: PASSED **");
      else
         $display("** keypad_scan_pin_entry_unit: FAILED **");
      $finish;
   end

endmodule
